[src/clpg_pkg.sv]
package clpg_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIM_W      = 13;
  localparam int STRIDE_W   = 14;
  localparam int IDX_W      = 25;
  localparam int COLOUR_W   = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = STRIDE_W;

  // delta magnitudes, error term and doubled error term
  localparam int DELTA_W = COORD_BITS + 1;
  localparam int ERR_W   = COORD_BITS + 3;
  localparam int E2_W    = ERR_W + 1;
  // wide enough to compare a non-negative coordinate against a screen size
  localparam int CMP_W   = COORD_BITS + DIM_W;
  localparam int PROD_W  = DIM_W + STRIDE_W;

  localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(480);
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(640);

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_STRIDE    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOUR_W-1:0]          colour_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         visible;
    logic [IDX_W-1:0]             word_index;
    logic [COLOUR_W-1:0]          colour_out;
    logic                         last;
  } out_item_t;

  // current pixel of the line in progress
  typedef struct packed {
    logic                         active;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic [COLOUR_W-1:0]          colour;
  } pix_t;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
  } screen_cfg_t;

endpackage

[src/clipped_line_pixel_generator_unit.sv]
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------
// in_      | input     | in_valid / in_stall | in_item_t (load / advance)
// out_     | output    | out_valid/out_stall | out_item_t (one pixel)
// cfg_     | input     | cfg_we              | cfg_addr, cfg_wdata
//
// One item per cycle while in_stall is low; an advance shows its pixel on out_ in the cycle after it is taken.
// The Bresenham state, one 13x14 multiply and the clip compares sit between
// the line state registers and the output register.
// Synchronous reset: idle, no line loaded, screen 640x480, stride 640.
// in_stall rises only while a held result beat is stalled on out_.
module clipped_line_pixel_generator_unit
  import clpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  screen_cfg_t cfg_r, cfg_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        in_fire;
  logic        emit;
  pix_t        pix;
  out_item_t   res;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign emit     = in_fire && (in_data.cmd == CMD_ADVANCE) && pix.active;

  clpg_stepper u_stepper (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (in_data),
    .pix   (pix)
  );

  clpg_pixel_map u_pixel_map (
    .pix (pix),
    .cfg (cfg_r),
    .res (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  cfg_nxt.width  = cfg_wdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.height = cfg_wdata[DIM_W-1:0];
        REG_ROW_STRIDE:    cfg_nxt.stride = cfg_wdata[STRIDE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      // drop the beat once taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.stride <= STRIDE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_clip_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |-> out_data.word_index == '0)
    else $error("clipped pixel carries a nonzero word index");

  a_visible_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |->
      !out_data.pixel_x[COORD_BITS-1] && !out_data.pixel_y[COORD_BITS-1])
    else $error("visible pixel has a negative coordinate");

  a_load_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd == CMD_LOAD |=> !out_valid)
    else $error("load produced a result beat");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && pix.last |=> !pix.active)
    else $error("line still active after its last pixel");
`endif

endmodule

[src/clpg_stepper.sv]
module clpg_stepper
  import clpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output pix_t     pix
);

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt;
  logic signed [COORD_BITS-1:0] tgt_y_r, tgt_y_nxt;
  logic [DELTA_W-1:0]           abs_dx_r, abs_dx_nxt;
  logic [DELTA_W-1:0]           abs_dy_r, abs_dy_nxt;
  logic                         x_neg_r, x_neg_nxt;
  logic                         y_neg_r, y_neg_nxt;
  logic signed [ERR_W-1:0]      err_r, err_nxt;
  logic [COLOUR_W-1:0]          colour_r, colour_nxt;

  logic signed [DELTA_W-1:0] dx, dy;
  logic [DELTA_W-1:0]        ld_abs_dx, ld_abs_dy;
  logic signed [E2_W-1:0]    e2, dx_e, dy_e;
  logic                      step_x, step_y;
  logic                      at_end;

  assign at_end = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);

  assign dx = DELTA_W'(item.end_x) - DELTA_W'(item.start_x);
  assign dy = DELTA_W'(item.end_y) - DELTA_W'(item.start_y);
  assign ld_abs_dx = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
  assign ld_abs_dy = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);

  assign e2   = {err_r, 1'b0};
  assign dx_e = E2_W'(signed'({1'b0, abs_dx_r}));
  assign dy_e = E2_W'(signed'({1'b0, abs_dy_r}));
  assign step_x = e2 > -dy_e;
  assign step_y = e2 < dx_e;

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    abs_dx_nxt = abs_dx_r;
    abs_dy_nxt = abs_dy_r;
    x_neg_nxt  = x_neg_r;
    y_neg_nxt  = y_neg_r;
    err_nxt    = err_r;
    colour_nxt = colour_r;
    if (fire) begin
      if (item.cmd == CMD_LOAD) begin
        active_nxt = 1'b1;
        cur_x_nxt  = item.start_x;
        cur_y_nxt  = item.start_y;
        tgt_x_nxt  = item.end_x;
        tgt_y_nxt  = item.end_y;
        abs_dx_nxt = ld_abs_dx;
        abs_dy_nxt = ld_abs_dy;
        x_neg_nxt  = !(!dx[DELTA_W-1] && (dx != '0));
        y_neg_nxt  = !(!dy[DELTA_W-1] && (dy != '0));
        err_nxt    = ERR_W'(signed'({1'b0, ld_abs_dx})) - ERR_W'(signed'({1'b0, ld_abs_dy}));
        colour_nxt = item.colour_in;
      end else if (active_r) begin
        if (at_end) begin
          active_nxt = 1'b0;
        end else begin
          err_nxt = err_r
                  - (step_x ? ERR_W'(signed'({1'b0, abs_dy_r})) : ERR_W'(0))
                  + (step_y ? ERR_W'(signed'({1'b0, abs_dx_r})) : ERR_W'(0));
          if (step_x) begin
            cur_x_nxt = x_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
          end
          if (step_y) begin
            cur_y_nxt = y_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      abs_dx_r <= '0;
      abs_dy_r <= '0;
      x_neg_r  <= 1'b0;
      y_neg_r  <= 1'b0;
      err_r    <= '0;
      colour_r <= '0;
    end else begin
      active_r <= active_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      abs_dx_r <= abs_dx_nxt;
      abs_dy_r <= abs_dy_nxt;
      x_neg_r  <= x_neg_nxt;
      y_neg_r  <= y_neg_nxt;
      err_r    <= err_nxt;
      colour_r <= colour_nxt;
    end
  end

  assign pix.active = active_r;
  assign pix.x      = cur_x_r;
  assign pix.y      = cur_y_r;
  assign pix.last   = at_end;
  assign pix.colour = colour_r;

endmodule

[src/clpg_pixel_map.sv]
module clpg_pixel_map
  import clpg_pkg::*;
(
  input  pix_t        pix,
  input  screen_cfg_t cfg,
  output out_item_t   res
);

  logic [CMP_W-1:0]  x_ext, y_ext;
  logic              vis;
  logic [PROD_W-1:0] row_base;
  logic [IDX_W-1:0]  idx;

  // a visible coordinate is non-negative and below a 13-bit size
  assign x_ext = CMP_W'(unsigned'(pix.x[COORD_BITS-2:0]));
  assign y_ext = CMP_W'(unsigned'(pix.y[COORD_BITS-2:0]));

  assign vis = !pix.x[COORD_BITS-1] && !pix.y[COORD_BITS-1]
            && (x_ext < CMP_W'(cfg.width)) && (y_ext < CMP_W'(cfg.height));

  assign row_base = PROD_W'(y_ext[DIM_W-1:0]) * PROD_W'(cfg.stride);
  assign idx = IDX_W'(row_base) + IDX_W'(x_ext[DIM_W-1:0]);

  assign res.pixel_x    = pix.x;
  assign res.pixel_y    = pix.y;
  assign res.visible    = vis;
  assign res.word_index = vis ? idx : '0;
  assign res.colour_out = pix.colour;
  assign res.last       = pix.last;

endmodule

[tb/clipped_line_pixel_generator_unit_tb.sv]
module clipped_line_pixel_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clpg_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 140;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_AT_BEAT  = 230;
  localparam int HOLD_CYCLES   = 300;
  localparam int CMAX          = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN          = -CMAX - 1;

  typedef struct packed {
    cmd_t cmd;
    int   sx;
    int   sy;
    int   ex;
    int   ey;
    int   colour;
    int   typed;
    int   wx;
    int   wy;
    int   wvis;
    int   widx;
    int   wcol;
    int   wlast;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // line walker state, mirrors the block
  bit       ln_active = 1'b0;
  int       ln_x = 0, ln_y = 0, ln_tx = 0, ln_ty = 0;
  int       ln_adx = 0, ln_ady = 0, ln_err = 0;
  bit       ln_xneg = 1'b0, ln_yneg = 1'b0;
  logic [COLOUR_W-1:0] ln_colour = '0;
  int       scr_width = 640, scr_height = 480, scr_stride = 640;

  out_item_t pix_q [$];
  int        errors     = 0;
  int        cycles     = 0;
  int        beats_done = 0;
  int        burst_left = 0;
  bit        finishing  = 1'b0;
  bit        hold_done  = 1'b0;
  dir_row_t  dir_rows [25];

  clipped_line_pixel_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_coord(int v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic in_item_t make_beat(cmd_t c, int sx, int sy, int ex, int ey,
                                         int col);
    in_item_t b;
    b.cmd       = c;
    b.start_x   = COORD_BITS'(sx);
    b.start_y   = COORD_BITS'(sy);
    b.end_x     = COORD_BITS'(ex);
    b.end_y     = COORD_BITS'(ey);
    b.colour_in = COLOUR_W'(col);
    return b;
  endfunction

  // advance with random payload; the block must ignore it
  function automatic in_item_t noise_advance();
    return make_beat(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // around the screen most of the time, on its edges, at the coordinate limits or anywhere
  function automatic int pick_coord(int span);
    int r;
    r = int'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, span + 3)) - 2;
      5, 6: begin
        case (r)
          0: return -1;
          1: return 0;
          2: return span - 1;
          default: return span;
        endcase
      end
      7: return ($urandom_range(0, 1) != 0) ? CMIN + r : CMAX - r;
      default: return int'($urandom_range(0, 65535)) + CMIN;
    endcase
  endfunction

  // Bresenham walk: load latches the line, advance emits the current pixel then steps
  function automatic bit plot_next(input in_item_t b, output out_item_t px);
    int  dx, dy, e2;
    bit  vis;
    longint idx;
    px = '0;
    if (b.cmd == CMD_LOAD) begin
      ln_x      = b.start_x;
      ln_y      = b.start_y;
      ln_tx     = b.end_x;
      ln_ty     = b.end_y;
      dx        = ln_tx - ln_x;
      dy        = ln_ty - ln_y;
      ln_xneg   = !(dx > 0);
      ln_yneg   = !(dy > 0);
      ln_adx    = (dx < 0) ? -dx : dx;
      ln_ady    = (dy < 0) ? -dy : dy;
      ln_err    = ln_adx - ln_ady;
      ln_colour = b.colour_in;
      ln_active = 1'b1;
      return 1'b0;
    end
    if (!ln_active) return 1'b0;
    vis = (ln_x >= 0) && (ln_y >= 0) && (ln_x < scr_width) && (ln_y < scr_height);
    idx = vis ? longint'(ln_y) * longint'(scr_stride) + longint'(ln_x) : 64'sd0;
    px.pixel_x    = COORD_BITS'(ln_x);
    px.pixel_y    = COORD_BITS'(ln_y);
    px.visible    = vis;
    px.word_index = IDX_W'(idx);
    px.colour_out = ln_colour;
    px.last       = (ln_x == ln_tx) && (ln_y == ln_ty);
    if (px.last) begin
      ln_active = 1'b0;
    end else begin
      e2 = ln_err * 2;
      if (e2 > -ln_ady) begin
        ln_err -= ln_ady;
        ln_x   += ln_xneg ? -1 : 1;
      end
      if (e2 < ln_adx) begin
        ln_err += ln_adx;
        ln_y   += ln_yneg ? -1 : 1;
      end
    end
    return 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic deliver(input in_item_t b, input bit typed, input out_item_t want);
    int        gap;
    out_item_t px;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    if (plot_next(b, px)) begin
      pix_q.push_back(typed ? want : px);
      beats_done++;
    end else if (b.cmd == CMD_LOAD) begin
      beats_done++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pix_q.size() != 0) @(negedge clk);
    // a trailing load gives no beat, let it settle
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_screen(int w, int h, int s);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SCREEN_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_addr  <= REG_SCREEN_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_addr  <= REG_ROW_STRIDE;
    cfg_wdata <= CFG_DATA_W'(s);
    @(negedge clk);
    cfg_we    <= 1'b0;
    scr_width  = int'(unsigned'(DIM_W'(w)));
    scr_height = int'(unsigned'(DIM_W'(h)));
    scr_stride = int'(unsigned'(STRIDE_W'(s)));
    @(negedge clk);
  endtask

  task automatic random_stroke();
    int sx, sy, ex, ey, span, n, kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      deliver(noise_advance(), 1'b0, '0);
      return;
    end
    sx = pick_coord(scr_width);
    sy = pick_coord(scr_height);
    if (kind < 3) begin
      ex = pick_coord(scr_width);
      ey = pick_coord(scr_height);
    end else begin
      ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
      ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
    end
    span = (ex > sx) ? ex - sx : sx - ex;
    n    = (ey > sy) ? ey - sy : sy - ey;
    if (n > span) span = n;
    case (kind)
      3:       n = 0;
      4, 5:    n = $urandom_range(0, span + 3);
      default: n = span + 1;
    endcase
    // drop long lines partway through with the next load
    if (n > 40) n = $urandom_range(1, 40);
    deliver(make_beat(CMD_LOAD, sx, sy, ex, ey, $urandom), 1'b0, '0);
    repeat (n) deliver(noise_advance(), 1'b0, '0);
  endtask

  task automatic check_pixel(input out_item_t want, input out_item_t got);
    if (got.pixel_x !== want.pixel_x) begin
      $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
      errors++;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
      errors++;
    end
    if (got.visible !== want.visible) begin
      $error("visible: expected %0d, got %0d", want.visible, got.visible);
      errors++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
      errors++;
    end
    if (got.colour_out !== want.colour_out) begin
      $error("colour_out: expected %08h, got %08h", want.colour_out, got.colour_out);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pix_q.size() == 0) begin
        $error("unexpected pixel beat x=%0d y=%0d", out_data.pixel_x, out_data.pixel_y);
        errors++;
      end else begin
        check_pixel(pix_q.pop_front(), out_data);
      end
    end
  end

  // receiver stall patterns, plus one long hold to back the block up
  initial begin
    int mode, len, on, off, k;
    @(negedge clk);
    while (!finishing) begin
      if (!hold_done && beats_done >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 80);
        on   = $urandom_range(1, 4);
        off  = $urandom_range(1, 4);
        for (k = 0; k < len && !finishing; k++) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1) != 0;
            2:       out_stall <= (k % (on + off)) < on;
            default: out_stall <= $urandom_range(0, 4) != 0;
          endcase
          @(negedge clk);
        end
      end
    end
    out_stall <= 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    out_item_t w;
    int        target;
    dir_rows = '{
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_LOAD, 0, 0, 0, 0, 'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, -1, -1, -1, -1, 'hFFFF_FFFF, 1, 0, 0, 1, 0, 'hFFFF_FFFF, 1},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_LOAD, 639, 479, 640, 480, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 1, 639, 479, 1, 307199, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 1, 640, 480, 0, 0, 0, 1},
      '{CMD_LOAD, CMIN, CMIN, CMAX, CMAX, 'hA5A5_A5A5, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 1, CMIN, CMIN, 0, 0, 'hA5A5_A5A5, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_LOAD, CMAX, CMIN, CMIN, CMAX, 'h5A5A_5A5A, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_LOAD, 5, 5, 2, 9, 'h00C0_FFEE, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_LOAD, 10, 3, 10, 7, 'h1234_5678, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines on the reset screen
    foreach (dir_rows[i]) begin
      w.pixel_x    = COORD_BITS'(dir_rows[i].wx);
      w.pixel_y    = COORD_BITS'(dir_rows[i].wy);
      w.visible    = dir_rows[i].wvis != 0;
      w.word_index = IDX_W'(dir_rows[i].widx);
      w.colour_out = COLOUR_W'(dir_rows[i].wcol);
      w.last       = dir_rows[i].wlast != 0;
      deliver(make_beat(dir_rows[i].cmd, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                        dir_rows[i].ey, dir_rows[i].colour),
              dir_rows[i].typed != 0, w);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: set_screen(1, 1, 1);
          2: set_screen(0, 0, 0);
          3: set_screen(4096, 4096, 8192);
          4: set_screen(8191, 8191, 16383);
          5: set_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
                        $urandom_range(1, 8192));
          6: set_screen(37, 0, 100);
          default: set_screen(640, 480, 640);
        endcase
      end
      target = beats_done + PHASE_BEATS;
      while (beats_done < target) random_stroke();
    end

    drain();
    finishing = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pix_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
